// ----- hw/rtl/gsc_pkg.sv -----
`timescale 1ns / 1ps

package gsc_pkg;

    // calendar constants
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned EPOCH_SHIFT  = 3657;
    localparam int unsigned CYCLE_DAYS   = 1461;
    localparam int unsigned BASE_YEAR    = 1970;

    // pipeline depth: three stages for the day split, six for the calendar
    localparam int unsigned DAY_STAGES = 3;
    localparam int unsigned CAL_STAGES = 6;
    localparam int unsigned NUM_STAGES = DAY_STAGES + CAL_STAGES;

    // reciprocals for division by constant, each estimate is low by at most one
    localparam logic [31:0] RECIP_DAY  = 32'((64'd1 << 48) / SECS_PER_DAY);
    localparam logic [13:0] RECIP_CYC  = 14'((64'd1 << 24) / CYCLE_DAYS);
    localparam logic [16:0] RECIP_MIN  = 17'((64'd1 << 22) / SECS_PER_MIN);
    localparam logic [10:0] RECIP_HOUR = 11'((64'd1 << 16) / SECS_PER_MIN);

    // day of the cycle at which each year of the four-year cycle starts
    localparam logic [10:0] YEAR1_START = 11'd365;
    localparam logic [10:0] YEAR2_START = 11'd730;
    localparam logic [10:0] YEAR3_START = 11'd1096;
    localparam logic [1:0]  LEAP_YEAR_IDX = 2'd2;

    typedef struct packed {
        logic [CAL_STAGES-1:0] cal;
        logic [DAY_STAGES-1:0] day;
    } stage_en_t;

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] sod;
        logic [31:0] frac;
    } day_split_t;

    // zero-based day of year on which each month index 0..11 starts
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mi);
        logic [8:0] s;
        begin
            case (mi)
                4'd0:    s = 9'd0;
                4'd1:    s = 9'd31;
                4'd2:    s = 9'd59;
                4'd3:    s = 9'd90;
                4'd4:    s = 9'd120;
                4'd5:    s = 9'd151;
                4'd6:    s = 9'd181;
                4'd7:    s = 9'd212;
                4'd8:    s = 9'd243;
                4'd9:    s = 9'd273;
                4'd10:   s = 9'd304;
                4'd11:   s = 9'd334;
                default: s = 9'd0;
            endcase
            if (leap && (mi >= 4'd2)) begin
                s = s + 9'd1;
            end
            return s;
        end
    endfunction

endpackage

// ----- hw/rtl/gps_seconds_to_calendar_top.sv -----
`timescale 1ns / 1ps

// gps timestamp to calendar converter: takes whole seconds since 1980-01-06
// 00:00:00 plus a 0.32 fixed-point fraction and returns year, month, day,
// hour, minute and second; the fraction comes out unchanged in fraction_out.
// one result per transaction through the nine-stage pipeline; a new
// transaction can be taken every cycle and a stalled output only backs up
// as far as the pipeline is full.
// every leap year is a plain fourth year from 1972 on (2100 included) and no
// leap seconds are applied.

module gps_seconds_to_calendar_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input transaction
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_whole_seconds,
    input  logic [31:0] s_second_fraction,
    // result transaction
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic [31:0] m_fraction_out
);

    // per-stage load enables, valid bits live in the controller
    gsc_pkg::stage_en_t  stage_en;
    // day count on the 1970 base, seconds of the day and the fraction
    gsc_pkg::day_split_t split;

    gsc_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    // stages 1-3: divide by seconds per day with a reciprocal multiply
    gsc_day_split u_day (
        .aclk            (aclk),
        .en              (stage_en.day),
        .whole_seconds   (s_whole_seconds),
        .second_fraction (s_second_fraction),
        .split           (split)
    );

    // stages 4-9: four-year cycle, year, month, day and time of day
    gsc_cal_split u_cal (
        .aclk         (aclk),
        .en           (stage_en.cal),
        .split        (split),
        .year         (m_year),
        .month        (m_month),
        .day_of_month (m_day_of_month),
        .hour         (m_hour),
        .minute       (m_minute),
        .second       (m_second),
        .fraction_out (m_fraction_out)
    );

endmodule

// ----- hw/rtl/gsc_pipe_ctrl.sv -----
`timescale 1ns / 1ps

module gsc_pipe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output gsc_pkg::stage_en_t  stage_en
);

    localparam int unsigned N = gsc_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] adv;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        adv[N-1] = !valid_reg[N-1] || m_ready;
        for (int i = N - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < N; i++) begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready  = adv[0];
    assign m_valid  = valid_reg[N-1];
    assign stage_en = adv;

endmodule

// ----- hw/rtl/gsc_day_split.sv -----
`timescale 1ns / 1ps

module gsc_day_split (
    input  logic                                aclk,
    input  logic [gsc_pkg::DAY_STAGES-1:0]      en,
    input  logic [31:0]                         whole_seconds,
    input  logic [31:0]                         second_fraction,
    output gsc_pkg::day_split_t                 split
);

    // stage 1: reciprocal product
    logic [63:0] prod_reg;
    logic [31:0] ws1_reg;
    logic [31:0] frac1_reg;
    // stage 2: estimate and remainder
    logic [15:0] qest_reg;
    logic [17:0] rem_reg;
    logic [31:0] frac2_reg;
    // stage 3: corrected day count on the 1970 base
    logic [15:0] days_reg;
    logic [16:0] sod_reg;
    logic [31:0] frac3_reg;

    logic [15:0] qest_next;
    logic [31:0] rem_wide;
    logic        over;

    always_comb begin
        qest_next = prod_reg[63:48];
        rem_wide  = ws1_reg - (32'(qest_next) * 32'(gsc_pkg::SECS_PER_DAY));
        over      = (rem_reg >= 18'(gsc_pkg::SECS_PER_DAY));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg  <= 64'(whole_seconds) * 64'(gsc_pkg::RECIP_DAY);
            ws1_reg   <= whole_seconds;
            frac1_reg <= second_fraction;
        end
        if (en[1]) begin
            qest_reg  <= qest_next;
            rem_reg   <= rem_wide[17:0];
            frac2_reg <= frac1_reg;
        end
        if (en[2]) begin
            days_reg  <= qest_reg + 16'(over) + 16'(gsc_pkg::EPOCH_SHIFT);
            sod_reg   <= over ? 17'(rem_reg - 18'(gsc_pkg::SECS_PER_DAY)) : rem_reg[16:0];
            frac3_reg <= frac2_reg;
        end
    end

    assign split.days = days_reg;
    assign split.sod  = sod_reg;
    assign split.frac = frac3_reg;

endmodule

// ----- hw/rtl/gsc_cal_split.sv -----
`timescale 1ns / 1ps

module gsc_cal_split (
    input  logic                                aclk,
    input  logic [gsc_pkg::CAL_STAGES-1:0]      en,
    input  gsc_pkg::day_split_t                 split,
    output logic [11:0]                         year,
    output logic [3:0]                          month,
    output logic [4:0]                          day_of_month,
    output logic [4:0]                          hour,
    output logic [5:0]                          minute,
    output logic [5:0]                          second,
    output logic [31:0]                         fraction_out
);

    // stage 4: reciprocal products for cycle and minute
    logic [29:0] cprod_reg;
    logic [32:0] mprod_reg;
    logic [15:0] dd4_reg;
    logic [16:0] sod4_reg;
    logic [31:0] frac4_reg;
    // stage 5: estimates and remainders
    logic [5:0]  cest_reg;
    logic [11:0] crem_reg;
    logic [10:0] mest_reg;
    logic [6:0]  srem_reg;
    logic [31:0] frac5_reg;
    // stage 6: corrected cycle, day of cycle, minute of day, second
    logic [5:0]  cyc6_reg;
    logic [10:0] doc_reg;
    logic [10:0] tmin6_reg;
    logic [5:0]  sec6_reg;
    logic [31:0] frac6_reg;
    // stage 7: year in cycle, day of year, hour product
    logic [5:0]  cyc7_reg;
    logic [1:0]  yic7_reg;
    logic [8:0]  doy7_reg;
    logic [20:0] hprod_reg;
    logic [10:0] tmin7_reg;
    logic [5:0]  sec7_reg;
    logic [31:0] frac7_reg;
    // stage 8: month index, hour estimate
    logic [5:0]  cyc8_reg;
    logic [1:0]  yic8_reg;
    logic [8:0]  doy8_reg;
    logic [3:0]  mi8_reg;
    logic [4:0]  hest_reg;
    logic [6:0]  hrem_reg;
    logic [5:0]  sec8_reg;
    logic [31:0] frac8_reg;
    // stage 9: output registers
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  dom_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [31:0] frac9_reg;

    logic [5:0]  cest_next;
    logic [16:0] crem_wide;
    logic [10:0] mest_next;
    logic [16:0] srem_wide;
    logic        c_over;
    logic        s_over;
    logic [1:0]  yic_next;
    logic [10:0] ystart;
    logic [10:0] doy_wide;
    logic [4:0]  hest_next;
    logic [10:0] hrem_wide;
    logic [3:0]  mi_next;
    logic        leap8;
    logic        h_over;
    logic [8:0]  mstart;

    always_comb begin
        cest_next = cprod_reg[29:24];
        crem_wide = 17'(dd4_reg) - (17'(cest_next) * 17'(gsc_pkg::CYCLE_DAYS));
        mest_next = mprod_reg[32:22];
        srem_wide = sod4_reg - (17'(mest_next) * 17'(gsc_pkg::SECS_PER_MIN));

        c_over = (crem_reg >= 12'(gsc_pkg::CYCLE_DAYS));
        s_over = (srem_reg >= 7'(gsc_pkg::SECS_PER_MIN));

        // which year of the four-year cycle
        if (doc_reg >= gsc_pkg::YEAR3_START) begin
            yic_next = 2'd3;
            ystart   = gsc_pkg::YEAR3_START;
        end else if (doc_reg >= gsc_pkg::YEAR2_START) begin
            yic_next = 2'd2;
            ystart   = gsc_pkg::YEAR2_START;
        end else if (doc_reg >= gsc_pkg::YEAR1_START) begin
            yic_next = 2'd1;
            ystart   = gsc_pkg::YEAR1_START;
        end else begin
            yic_next = 2'd0;
            ystart   = '0;
        end
        doy_wide = doc_reg - ystart;

        hest_next = hprod_reg[20:16];
        hrem_wide = tmin7_reg - (11'(hest_next) * 11'(gsc_pkg::SECS_PER_MIN));

        // month index counts the month starts already passed
        leap8   = (yic7_reg == gsc_pkg::LEAP_YEAR_IDX);
        mi_next = '0;
        for (int k = 1; k < 12; k++) begin
            if (doy7_reg >= gsc_pkg::month_start(leap8, 4'(k))) begin
                mi_next = mi_next + 4'd1;
            end
        end

        h_over = (hrem_reg >= 7'(gsc_pkg::SECS_PER_MIN));
        mstart = gsc_pkg::month_start(yic8_reg == gsc_pkg::LEAP_YEAR_IDX, mi8_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            cprod_reg <= 30'(split.days) * 30'(gsc_pkg::RECIP_CYC);
            mprod_reg <= 33'(split.sod) * 33'(gsc_pkg::RECIP_MIN);
            dd4_reg   <= split.days;
            sod4_reg  <= split.sod;
            frac4_reg <= split.frac;
        end
        if (en[1]) begin
            cest_reg  <= cest_next;
            crem_reg  <= crem_wide[11:0];
            mest_reg  <= mest_next;
            srem_reg  <= srem_wide[6:0];
            frac5_reg <= frac4_reg;
        end
        if (en[2]) begin
            cyc6_reg  <= cest_reg + 6'(c_over);
            doc_reg   <= c_over ? 11'(crem_reg - 12'(gsc_pkg::CYCLE_DAYS)) : crem_reg[10:0];
            tmin6_reg <= mest_reg + 11'(s_over);
            sec6_reg  <= s_over ? 6'(srem_reg - 7'(gsc_pkg::SECS_PER_MIN)) : srem_reg[5:0];
            frac6_reg <= frac5_reg;
        end
        if (en[3]) begin
            cyc7_reg  <= cyc6_reg;
            yic7_reg  <= yic_next;
            doy7_reg  <= doy_wide[8:0];
            hprod_reg <= 21'(tmin6_reg) * 21'(gsc_pkg::RECIP_HOUR);
            tmin7_reg <= tmin6_reg;
            sec7_reg  <= sec6_reg;
            frac7_reg <= frac6_reg;
        end
        if (en[4]) begin
            cyc8_reg  <= cyc7_reg;
            yic8_reg  <= yic7_reg;
            doy8_reg  <= doy7_reg;
            mi8_reg   <= mi_next;
            hest_reg  <= hest_next;
            hrem_reg  <= hrem_wide[6:0];
            sec8_reg  <= sec7_reg;
            frac8_reg <= frac7_reg;
        end
        if (en[5]) begin
            year_reg   <= 12'(gsc_pkg::BASE_YEAR) + {4'd0, cyc8_reg, 2'b00} + 12'(yic8_reg);
            month_reg  <= mi8_reg + 4'd1;
            dom_reg    <= 5'(doy8_reg - mstart + 9'd1);
            hour_reg   <= hest_reg + 5'(h_over);
            minute_reg <= h_over ? 6'(hrem_reg - 7'(gsc_pkg::SECS_PER_MIN)) : hrem_reg[5:0];
            second_reg <= sec8_reg;
            frac9_reg  <= frac8_reg;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign fraction_out = frac9_reg;

endmodule

// ----- verif/tb_gps_seconds_to_calendar_top.sv -----
`timescale 1ns / 1ps

module tb_gps_seconds_to_calendar_top;

    // seconds and days used by the calendar prediction
    localparam int unsigned DAY_SECONDS   = 86400;
    localparam int unsigned HOUR_SECONDS  = 3600;
    localparam int unsigned MIN_SECONDS   = 60;
    localparam int unsigned GPS_DAY_SHIFT = 3657;   // 1970-01-01 to 1980-01-06
    localparam int unsigned QUAD_DAYS     = 1461;   // days in a four-year cycle
    localparam int unsigned QUAD_MONTHS   = 48;
    localparam int unsigned FIRST_YEAR    = 1970;

    // run control
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned IDLE_PERCENT  = 37;
    localparam int unsigned HOLD_CYCLES   = 64;     // long receiver hold-off
    localparam int unsigned TAIL_CYCLES   = 20;     // pipeline is nine deep
    localparam int unsigned STALL_LIMIT   = 2000;   // cycles with no transaction at all

    // one calendar result as it leaves the block
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] fraction;
    } cal_date_t;

    class calendar_scoreboard;
        cal_date_t   expected_dates[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // days in month idx of the cycle that starts with 1970, 1972 is the leap year
        static function int unsigned cycle_month_days(int unsigned idx);
            int unsigned m;
            m = idx % 12;
            case (m)
                1:          return ((idx / 12) == 2) ? 29 : 28;
                3, 5, 8, 10: return 30;
                default:    return 31;
            endcase
        endfunction

        // plain four-year leap rule, no leap seconds, fraction passes through
        static function cal_date_t gps_to_calendar(logic [31:0] whole, logic [31:0] frac);
            int unsigned days;
            int unsigned sod;
            int unsigned rem;
            int unsigned mon;
            cal_date_t   r;
            days = whole / DAY_SECONDS;
            sod  = whole - days * DAY_SECONDS;
            days = days + GPS_DAY_SHIFT;
            rem  = days % QUAD_DAYS;
            mon  = 0;
            while (mon < QUAD_MONTHS && rem >= cycle_month_days(mon)) begin
                rem = rem - cycle_month_days(mon);
                mon++;
            end
            if (mon >= QUAD_MONTHS) begin
                mon = QUAD_MONTHS - 1;
            end
            r.year         = 12'(FIRST_YEAR + (days / QUAD_DAYS) * 4 + mon / 12);
            r.month        = 4'(mon % 12 + 1);
            r.day_of_month = 5'(rem + 1);
            r.hour         = 5'(sod / HOUR_SECONDS);
            r.minute       = 6'((sod % HOUR_SECONDS) / MIN_SECONDS);
            r.second       = 6'(sod % MIN_SECONDS);
            r.fraction     = frac;
            return r;
        endfunction

        function void note_timestamp(logic [31:0] whole, logic [31:0] frac);
            expected_dates = {expected_dates, gps_to_calendar(whole, frac)};
        endfunction

        function void field_matches(string name, longint unsigned exp_val,
                                    longint unsigned act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                mismatch_count++;
            end
        endfunction

        function void check_date(cal_date_t got);
            cal_date_t want;
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                         $time, got.year, got.month, got.day_of_month,
                         got.hour, got.minute, got.second);
                mismatch_count++;
                return;
            end
            want = expected_dates.pop_front();
            field_matches("year", want.year, got.year);
            field_matches("month", want.month, got.month);
            field_matches("day_of_month", want.day_of_month, got.day_of_month);
            field_matches("hour", want.hour, got.hour);
            field_matches("minute", want.minute, got.minute);
            field_matches("second", want.second, got.second);
            field_matches("fraction_out", want.fraction, got.fraction);
        endfunction
    endclass

    // clock, reset and block ports; those the bench drives are known from time zero
    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [31:0] s_whole_seconds   = '0;
    logic [31:0] s_second_fraction = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic [31:0] m_fraction_out;

    // knobs shared between the stimulus thread and the receiver
    bit tx_idles     = 1'b1;
    bit rx_idles     = 1'b1;
    bit hold_request = 1'b0;

    calendar_scoreboard sb = new();

    gps_seconds_to_calendar_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_whole_seconds   (s_whole_seconds),
        .s_second_fraction (s_second_fraction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_year            (m_year),
        .m_month           (m_month),
        .m_day_of_month    (m_day_of_month),
        .m_hour            (m_hour),
        .m_minute          (m_minute),
        .m_second          (m_second),
        .m_fraction_out    (m_fraction_out)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // one monitor for both channels: inputs are noted before results are checked,
    // all values sampled as they stood before the edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_timestamp(s_whole_seconds, s_second_fraction);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_date({m_year, m_month, m_day_of_month, m_hour, m_minute,
                           m_second, m_fraction_out});
        end
    end

    // result side: random back-pressure, a clean stretch, and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (rx_idles) begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run when the block goes quiet for too long
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_gps_seconds_to_calendar_top: FAIL");
        $finish;
    end

    // offers one transaction, after a random gap if tx_idles is set, and returns at the
    // accepting edge; valid stays high on return so a following item goes out back to back
    task automatic send_timestamp(input logic [31:0] whole, input logic [31:0] frac);
        while (tx_idles && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_whole_seconds   <= whole;
        s_second_fraction <= frac;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // called at the accepting edge of the last transaction of a burst
    task automatic release_input();
        s_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.expected_dates.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // timestamps biased toward day, month, year and leap-day edges
    function automatic logic [31:0] pick_timestamp();
        int unsigned    quad;
        int unsigned    mon;
        int unsigned    start_day;
        longint unsigned whole;
        case ($urandom_range(0, 3))
            0, 1: begin
                whole = $urandom();
            end
            2: begin
                // first, last or any second of a random day
                whole = longint'($urandom_range(0, 49709)) * DAY_SECONDS;
                case ($urandom_range(0, 2))
                    0:       whole = whole;
                    1:       whole = whole + DAY_SECONDS - 1;
                    default: whole = whole + $urandom_range(0, DAY_SECONDS - 1);
                endcase
            end
            default: begin
                // first second of a month or the last second before it
                quad      = $urandom_range(3, 35);
                mon       = $urandom_range(0, QUAD_MONTHS - 1);
                start_day = quad * QUAD_DAYS;
                for (int unsigned i = 0; i < mon; i++) begin
                    start_day = start_day + calendar_scoreboard::cycle_month_days(i);
                end
                whole = longint'(start_day - GPS_DAY_SHIFT) * DAY_SECONDS;
                if ($urandom_range(0, 1) != 0) begin
                    whole = whole - 1;
                end
            end
        endcase
        return whole[31:0];
    endfunction

    task automatic send_random_burst(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_timestamp(pick_timestamp(), $urandom());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: epoch, largest input, day edges, leap days, 2100 as a leap year
        send_timestamp(32'd0,          32'd0);
        send_timestamp(32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_timestamp(32'd86399,      32'h8000_0000);
        send_timestamp(32'd86400,      32'h0000_0001);
        send_timestamp(32'd4665599,    32'h0000_0000);   // 1980-02-28 23:59:59
        send_timestamp(32'd4665600,    32'hFFFF_FFFF);   // 1980-02-29
        send_timestamp(32'd4752000,    32'h5555_5555);   // 1980-03-01
        send_timestamp(32'd31190399,   32'hAAAA_AAAA);   // 1980-12-31 23:59:59
        send_timestamp(32'd31190400,   32'h0000_0000);   // 1981-01-01
        send_timestamp(32'd635817600,  32'h1234_5678);   // 2000-02-29
        send_timestamp(32'd3791577599, 32'hFFFF_FFFF);   // 2100-02-28 23:59:59
        send_timestamp(32'd3791577600, 32'h0000_0000);   // 2100-02-29, no century exception
        send_timestamp(32'd3791664000, 32'h8765_4321);   // 2100-03-01
        send_timestamp(32'd86445296,   32'hFFFF_FFFF);   // 12:34:56 of some day

        // random with idling on both sides
        send_random_burst(200);

        // long stretch with no idling at all
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        send_random_burst(150);

        // receiver holds off while the sender keeps offering, pipeline fills and stalls input
        hold_request = 1'b1;
        send_random_burst(40);
        release_input();

        // sender pauses until every expected result has come out
        wait_for_results();

        tx_idles = 1'b1;
        rx_idles = 1'b1;
        send_random_burst(210);
        release_input();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.mismatch_count == 0 && sb.expected_dates.size() == 0) begin
            $display("tb_gps_seconds_to_calendar_top: PASS");
        end else begin
            $display("tb_gps_seconds_to_calendar_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/gsc_pkg.sv
hw/rtl/gsc_pipe_ctrl.sv
hw/rtl/gsc_day_split.sv
hw/rtl/gsc_cal_split.sv
hw/rtl/gps_seconds_to_calendar_top.sv
verif/tb_gps_seconds_to_calendar_top.sv
